// ===== rtl/core/obr_pkg.sv =====
// shared types and constants for the offset addressed byte ring
// no dependencies

package obr_pkg;

  localparam int unsigned PtrW     = 10;
  localparam int unsigned Capacity = 1 << PtrW;
  localparam int unsigned DataW    = 8;

  typedef enum logic [1:0] {
    OpPush    = 2'd0,
    OpSet     = 2'd1,
    OpRead    = 2'd2,
    OpDiscard = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [PtrW-1:0]  offset;
    logic [DataW-1:0] write_data;
    logic [PtrW-1:0]  discard_count;
    logic             request_last;
  } item_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [PtrW-1:0]  addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic            rd_hit;
    logic            at_end;
    logic            done;
    status_e         status;
    logic [PtrW-1:0] used_count;
    logic [PtrW-1:0] free_count;
  } res_t;

endpackage

// ===== rtl/core/obr_byte_ram.sv =====
// generic single port ram with registered read data
// no dependencies

module obr_byte_ram #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [1 << AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/obr_ptr_ctrl.sv =====
// head and tail pointers, per-operation checks and store access
// depends on obr_pkg

module obr_ptr_ctrl
  import obr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  item_t    item_i,
  output mem_req_t mem_req_o,
  output res_t     res_o
);

  localparam logic [PtrW-1:0] MaxUsed = PtrW'(Capacity - 1);

  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [PtrW-1:0] used;
  logic [PtrW-1:0] used_new;
  logic [PtrW-1:0] pos;
  logic            we;
  logic            re;
  logic            at_end;
  status_e         status;

  assign used = tail_q - head_q;
  assign pos  = head_q + item_i.offset;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    we     = 1'b0;
    re     = 1'b0;
    at_end = 1'b0;
    status = StOk;
    case (item_i.operation)
      OpPush: begin
        if (used == MaxUsed) begin
          status = StFull;
        end else begin
          we     = 1'b1;
          tail_d = tail_q + PtrW'(1);
        end
      end
      OpSet: begin
        // offset + 2 beyond capacity leaves no room with one slot kept free
        if (item_i.offset == MaxUsed) begin
          status = StFull;
        end else begin
          we = 1'b1;
          if (item_i.offset >= used) begin
            tail_d = pos + PtrW'(1);
          end
        end
      end
      OpRead: begin
        if (item_i.offset > used) begin
          status = StRange;
          at_end = 1'b1;
        end else if (item_i.offset == used) begin
          at_end = 1'b1;
        end else begin
          re     = 1'b1;
          at_end = (item_i.offset + PtrW'(1)) == used;
        end
      end
      OpDiscard: begin
        if (item_i.discard_count > used) begin
          status = StRange;
        end else begin
          head_d = head_q + item_i.discard_count;
        end
      end
      default: begin
        status = StOk;
      end
    endcase
  end

  assign used_new = tail_d - head_d;

  always_comb begin
    mem_req_o.we    = we & advance_i;
    mem_req_o.re    = re & advance_i;
    mem_req_o.addr  = (item_i.operation == OpPush) ? tail_q : pos;
    mem_req_o.wdata = item_i.write_data;
  end

  always_comb begin
    res_o.rd_hit     = re;
    res_o.at_end     = at_end;
    res_o.done       = item_i.request_last | at_end;
    res_o.status     = status;
    res_o.used_count = used_new;
    res_o.free_count = MaxUsed - used_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (advance_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule

// ===== rtl/core/offset_addressed_byte_ring_unit.sv =====
// offset addressed byte ring: top level with input and result registers
// depends on obr_pkg, obr_ptr_ctrl and obr_byte_ram
//
// usage:
//   in channel (in_valid_i/in_ready_o) carries one operation per transfer:
//   push, set at offset, read at offset or discard. out channel
//   (out_valid_o/out_ready_i) returns exactly one result per item, in order,
//   with the read byte, end and done flags, status and used/free counts.
//   out_valid_o rises once the item has moved from the input register into
//   the result register. the item sits in the input register while the
//   pointer update and the store access happen, and the registered read
//   data forms the result register together with the flags.
//   throughput is one item per cycle while out_ready_i stays high.
//   when the receiver stalls, the result register holds, the input register
//   holds the next item and in_ready_o drops once both are occupied.
//   reset empties the ring (head and tail at zero) and both registers; the
//   byte store has no clearing pass, so a gap byte read before it was
//   written returns an arbitrary value.

module offset_addressed_byte_ring_unit
  import obr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [PtrW-1:0]   offset_i,
  input  logic [DataW-1:0]  write_data_i,
  input  logic [PtrW-1:0]   discard_count_i,
  input  logic              request_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DataW-1:0]  read_data_o,
  output logic              at_end_o,
  output logic              request_done_o,
  output logic [1:0]        status_o,
  output logic [PtrW-1:0]   used_count_o,
  output logic [PtrW-1:0]   free_count_o
);

  logic             a_valid_q;
  item_t            a_item_q;
  logic             out_valid_q;
  res_t             res_q;
  res_t             res_d;
  mem_req_t         mem_req;
  logic [DataW-1:0] ram_rdata;
  logic             advance;
  logic             in_xfer;

  // the input stage moves on whenever the result register is free or drains
  assign advance    = a_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~a_valid_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_item_q.operation     <= op_e'(operation_i);
      a_item_q.offset        <= offset_i;
      a_item_q.write_data    <= write_data_i;
      a_item_q.discard_count <= discard_count_i;
      a_item_q.request_last  <= request_last_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  obr_ptr_ctrl u_ptr_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (a_item_q),
    .mem_req_o (mem_req),
    .res_o     (res_d)
  );

  obr_byte_ram #(
    .AddrW (PtrW),
    .DataW (DataW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = res_q.rd_hit ? ram_rdata : '0;
  assign at_end_o       = res_q.at_end;
  assign request_done_o = res_q.done;
  assign status_o       = res_q.status;
  assign used_count_o   = res_q.used_count;
  assign free_count_o   = res_q.free_count;

`ifndef SYNTHESIS
  // counts always add up to the usable capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (PtrW'(used_count_o + free_count_o) == PtrW'(Capacity - 1)))
    else $error("used and free counts do not add up");

  // a read past used data returns no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StRange && at_end_o) |-> (read_data_o == '0))
    else $error("out of range read returned data");

  // input only stalls with both registers occupied and the receiver stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without back pressure");
`endif

endmodule

// ===== tb/sv/offset_addressed_byte_ring_unit_tb.sv =====
// testbench for offset_addressed_byte_ring_unit: directed and random ring operations
// checked against an in-bench ring predictor held in a small scoreboard class
// depends on obr_pkg and the offset_addressed_byte_ring_unit rtl

module offset_addressed_byte_ring_unit_tb
  import obr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomOps   = 1200;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAtOp    = 300;
  localparam int unsigned BurstFirst  = 550;
  localparam int unsigned BurstLast   = 850;

  typedef enum int {
    MixTraffic,
    FillTraffic,
    DrainTraffic
  } traffic_e;

  typedef struct {
    logic [DataW-1:0] read_data;
    logic             at_end;
    logic             request_done;
    status_e          status;
    logic [PtrW-1:0]  used_count;
    logic [PtrW-1:0]  free_count;
  } ring_result_t;

  class byte_ring_scoreboard;
    logic [DataW-1:0] ring_bytes [Capacity];
    bit               slot_written [Capacity];
    logic [PtrW-1:0]  head_ptr;
    logic [PtrW-1:0]  tail_ptr;
    ring_result_t     pending_results [$];
    int unsigned      mismatches;

    function new();
      head_ptr   = '0;
      tail_ptr   = '0;
      mismatches = 0;
      foreach (slot_written[i]) slot_written[i] = 1'b0;
    endfunction

    function int unsigned held_bytes();
      logic [PtrW-1:0] diff;
      diff = tail_ptr - head_ptr;
      return diff;
    endfunction

    // false only for a byte inside the used data that was never written
    function bit slot_readable(int unsigned off);
      logic [PtrW-1:0] pos;
      if (off >= held_bytes()) return 1'b1;
      pos = head_ptr + PtrW'(off);
      return slot_written[pos];
    endfunction

    function void note_operation(op_e op, logic [PtrW-1:0] off, logic [DataW-1:0] wdata,
                                 logic [PtrW-1:0] dcount, logic last);
      ring_result_t    r;
      int unsigned     used;
      int unsigned     offs;
      logic [PtrW-1:0] pos;
      used           = held_bytes();
      offs           = off;
      pos            = head_ptr + off;
      r.read_data    = '0;
      r.at_end       = 1'b0;
      r.request_done = last;
      r.status       = StOk;
      case (op)
        OpPush: begin
          if (used >= Capacity - 1) begin
            r.status = StFull;
          end else begin
            ring_bytes[tail_ptr]   = wdata;
            slot_written[tail_ptr] = 1'b1;
            tail_ptr               = tail_ptr + 1'b1;
          end
        end
        OpSet: begin
          if (offs + 2 > Capacity) begin
            r.status = StFull;
          end else begin
            ring_bytes[pos]   = wdata;
            slot_written[pos] = 1'b1;
            // writing past the used data moves the tail and leaves a gap
            if (offs + 1 > used) tail_ptr = pos + 1'b1;
          end
        end
        OpRead: begin
          if (offs > used) begin
            r.status = StRange;
            r.at_end = 1'b1;
          end else if (offs == used) begin
            r.at_end = 1'b1;
          end else begin
            r.read_data = ring_bytes[pos];
            r.at_end    = (offs + 1 >= used);
          end
          r.request_done = last | r.at_end;
        end
        OpDiscard: begin
          if (int'(dcount) > int'(used)) r.status = StRange;
          else head_ptr = head_ptr + dcount;
        end
      endcase
      used         = held_bytes();
      r.used_count = PtrW'(used);
      r.free_count = PtrW'(Capacity - 1 - used);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(logic [DataW-1:0] read_data, logic at_end, logic request_done,
                               logic [1:0] status, logic [PtrW-1:0] used_count,
                               logic [PtrW-1:0] free_count);
      ring_result_t r;
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation pending");
        mismatches++;
        return;
      end
      r = pending_results.pop_front();
      compare_field("read_data", r.read_data, read_data);
      compare_field("at_end", r.at_end, at_end);
      compare_field("request_done", r.request_done, request_done);
      compare_field("status", r.status, status);
      compare_field("used_count", r.used_count, used_count);
      compare_field("free_count", r.free_count, free_count);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        operation_i;
  logic [PtrW-1:0]   offset_i;
  logic [DataW-1:0]  write_data_i;
  logic [PtrW-1:0]   discard_count_i;
  logic              request_last_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DataW-1:0]  read_data_o;
  logic              at_end_o;
  logic              request_done_o;
  logic [1:0]        status_o;
  logic [PtrW-1:0]   used_count_o;
  logic [PtrW-1:0]   free_count_o;

  byte_ring_scoreboard ring_sb;
  int unsigned         ops_accepted;

  offset_addressed_byte_ring_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .offset_i       (offset_i),
    .write_data_i   (write_data_i),
    .discard_count_i(discard_count_i),
    .request_last_i (request_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .at_end_o       (at_end_o),
    .request_done_o (request_done_o),
    .status_o       (status_o),
    .used_count_o   (used_count_o),
    .free_count_o   (free_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // offers one operation and returns once its transfer has happened
  task automatic send_op(op_e op, logic [PtrW-1:0] off, logic [DataW-1:0] wdata,
                         logic [PtrW-1:0] dcount, logic last);
    @(negedge clk_i);
    while ((ops_accepted < BurstFirst || ops_accepted >= BurstLast) &&
           $urandom_range(0, 99) < 25) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    operation_i     = op;
    offset_i        = off;
    write_data_i    = wdata;
    discard_count_i = dcount;
    request_last_i  = last;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ring_sb.note_operation(op, off, wdata, dcount, last);
    ops_accepted++;
  endtask

  task automatic send_random_op(traffic_e mode);
    op_e              op;
    logic [PtrW-1:0]  off;
    logic [PtrW-1:0]  dcount;
    logic [DataW-1:0] wdata;
    logic             last;
    int unsigned      used;
    int unsigned      roll;
    int unsigned      cand;
    int unsigned      push_lim;
    int unsigned      set_lim;
    int unsigned      read_lim;
    bit               found;
    used   = ring_sb.held_bytes();
    off    = PtrW'($urandom_range(0, 1023));
    dcount = PtrW'($urandom_range(0, 1023));
    wdata  = DataW'($urandom_range(0, 255));
    last   = ($urandom_range(0, 3) == 0);
    case (mode)
      FillTraffic:  begin push_lim = 60; set_lim = 85; read_lim = 95; end
      DrainTraffic: begin push_lim = 10; set_lim = 15; read_lim = 50; end
      default:      begin push_lim = 30; set_lim = 50; read_lim = 85; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_lim) begin
      op = OpPush;
    end else if (roll < set_lim) begin
      op   = OpSet;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        off = PtrW'($urandom_range(0, used));
      end else if (roll < 85) begin
        off = (used + 16 > 1023) ? 10'd1023 : PtrW'(used + $urandom_range(1, 16));
      end
    end else if (roll < read_lim) begin
      op = OpRead;
      if ($urandom_range(0, 4) != 0 && used > 0) begin
        // aim inside the used data but never at a gap byte left unwritten
        found = 1'b0;
        off   = PtrW'(used);
        for (int k = 0; k < 8 && !found; k++) begin
          cand = $urandom_range(0, used - 1);
          if (ring_sb.slot_readable(cand)) begin
            off   = PtrW'(cand);
            found = 1'b1;
          end
        end
      end else if (!ring_sb.slot_readable(off)) begin
        off = PtrW'(used);
      end
    end else begin
      op = OpDiscard;
      if ($urandom_range(0, 4) != 0) dcount = PtrW'($urandom_range(0, used));
    end
    send_op(op, off, wdata, dcount, last);
  endtask

  // result side: random stalls, one long hold-off, then a stall-free stretch
  initial begin
    bit held_off;
    held_off    = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_off && ops_accepted >= HoldAtOp) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        held_off = 1'b1;
      end else if (ops_accepted >= BurstFirst + 50 && ops_accepted < BurstLast) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        ring_sb.check_result(read_data_o, at_end_o, request_done_o, status_o,
                             used_count_o, free_count_o);
      end
    end
  end

  // ends the run when no transfer happens on either side for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    traffic_e mode;
    ring_sb         = new();
    ops_accepted    = 0;
    mode            = MixTraffic;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = OpPush;
    offset_i        = '0;
    write_data_i    = '0;
    discard_count_i = '0;
    request_last_i  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty ring: read at used, read past used, discard beyond used, discard nothing
    send_op(OpRead, 10'd0, 8'h00, 10'd0, 1'b0);
    send_op(OpRead, 10'd1023, 8'h00, 10'd0, 1'b0);
    send_op(OpDiscard, 10'd0, 8'h00, 10'd1, 1'b0);
    send_op(OpDiscard, 10'd0, 8'h00, 10'd0, 1'b1);
    send_op(OpPush, 10'd0, 8'h00, 10'd0, 1'b0);
    send_op(OpPush, 10'd0, 8'hff, 10'd0, 1'b1);
    send_op(OpRead, 10'd0, 8'h00, 10'd0, 1'b0);
    send_op(OpRead, 10'd1, 8'h00, 10'd0, 1'b0);
    send_op(OpRead, 10'd2, 8'h00, 10'd0, 1'b0);
    // set beyond capacity, then a set at the last slot fills the ring with a gap
    send_op(OpSet, 10'd1023, 8'h11, 10'd0, 1'b0);
    send_op(OpSet, 10'd1022, 8'ha5, 10'd0, 1'b0);
    send_op(OpPush, 10'd0, 8'h5a, 10'd0, 1'b0);
    send_op(OpRead, 10'd1022, 8'h00, 10'd0, 1'b0);
    send_op(OpRead, 10'd1023, 8'h00, 10'd0, 1'b1);
    send_op(OpSet, 10'd3, 8'h3c, 10'd0, 1'b0);
    send_op(OpRead, 10'd3, 8'h00, 10'd0, 1'b0);
    send_op(OpDiscard, 10'd0, 8'h00, 10'd1023, 1'b0);
    send_op(OpDiscard, 10'd0, 8'h00, 10'd1023, 1'b0);
    // head now sits at the top slot, so any nonzero offset wraps around
    send_op(OpSet, 10'd5, 8'h81, 10'd0, 1'b1);
    send_op(OpRead, 10'd5, 8'h00, 10'd0, 1'b0);
    send_op(OpSet, 10'd0, 8'h7e, 10'd0, 1'b0);
    send_op(OpRead, 10'd0, 8'h00, 10'd0, 1'b0);
    send_op(OpPush, 10'd0, 8'hff, 10'd0, 1'b0);
    send_op(OpDiscard, 10'd0, 8'h00, 10'd7, 1'b1);

    for (int i = 0; i < RandomOps; i++) begin
      if (i % 50 == 0) mode = traffic_e'($urandom_range(0, 2));
      send_random_op(mode);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (ring_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (ring_sb.mismatches == 0 && ring_sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
